>>> design/mmcs_pkg.sv
package mmcs_pkg;

	localparam int PIXEL_WIDTH = 16;
	localparam int DATA_W      = 16;

	localparam logic [DATA_W-1:0] WIDE_MAX   = DATA_W'((32'd1 << PIXEL_WIDTH) - 32'd1);
	localparam logic [DATA_W-1:0] NARROW_MAX = DATA_W'(255);

	// Remap job queue between front and back.
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Configuration register indexes.
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_PIXEL_FORMAT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OUT_MIN      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_OUT_MAX      = 2'd2;

	// Action codes.
	localparam logic ACT_MEASURE = 1'b0;
	localparam logic ACT_REMAP   = 1'b1;

	// Pixel format codes.
	localparam logic FMT_NARROW = 1'b0;
	localparam logic FMT_WIDE   = 1'b1;

	// Divider sizing: the rounded numerator is below 2^35, the divisor 2*R below 2^17.
	localparam int NUM_W      = 36;
	localparam int DIVIDEND_W = 35;
	localparam int DIVISOR_W  = 17;
	localparam int DIV_CNT_W  = $clog2(DIVIDEND_W + 1);

	typedef struct packed {
		logic [DATA_W-1:0] pixel;
		logic [DATA_W-1:0] min_seen;
		logic [DATA_W-1:0] max_seen;
	} remap_job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

	function automatic logic [DATA_W-1:0] format_max(input logic fmt);
		return (fmt == FMT_WIDE) ? WIDE_MAX : NARROW_MAX;
	endfunction

endpackage

>>> design/mmcs_queue.sv
module mmcs_queue
	import mmcs_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  remap_job_t    push_job,
	input  logic          pop,
	output remap_job_t    head_job,
	output queue_status_t status
);

	remap_job_t        mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] ptr);
		return (ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : ptr + QPTR_W'(1);
	endfunction

	assign status.full  = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign status.empty = (count_q == '0);
	assign head_job     = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QUEUE_DEPTH))
		else $error("queue count above depth");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		status.full |-> !push)
		else $error("push into a full queue");

endmodule

>>> design/mmcs_front.sv
module mmcs_front
	import mmcs_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              action,
	input  logic [DATA_W-1:0] pixel_value,
	input  logic              frame_start,
	input  logic              pixel_format,
	input  queue_status_t     q_status,
	output logic              push,
	output remap_job_t        push_job
);

	logic [DATA_W-1:0] min_q;
	logic [DATA_W-1:0] max_q;
	logic [DATA_W-1:0] fmax;
	logic [DATA_W-1:0] pix;
	logic [DATA_W-1:0] base_min;
	logic [DATA_W-1:0] base_max;
	logic              accept;

	assign in_stall = q_status.full;
	assign accept   = in_valid && !in_stall;
	assign fmax     = format_max(pixel_format);
	assign pix      = pixel_value & fmax;

	// A frame start restarts the measurement before this pixel is counted.
	assign base_min = frame_start ? fmax : min_q;
	assign base_max = frame_start ? '0 : max_q;

	// Remap beats take a snapshot of the measured range along with them.
	assign push              = accept && (action == ACT_REMAP);
	assign push_job.pixel    = pix;
	assign push_job.min_seen = min_q;
	assign push_job.max_seen = max_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= WIDE_MAX;
			max_q <= '0;
		end else if (accept && (action == ACT_MEASURE)) begin
			min_q <= (pix < base_min) ? pix : base_min;
			max_q <= (pix > base_max) ? pix : base_max;
		end
	end

	a_range_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (action == ACT_MEASURE)) |=> (min_q <= max_q))
		else $error("measured range inverted after a measure beat");

endmodule

>>> design/mmcs_back.sv
module mmcs_back
	import mmcs_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  queue_status_t     q_status,
	input  remap_job_t        head_job,
	output logic              pop,
	input  logic              pixel_format,
	input  logic [DATA_W-1:0] out_min,
	input  logic [DATA_W-1:0] out_max,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [DATA_W-1:0] pixel_out
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL,
		S_SUM,
		S_DIV,
		S_CLAMP,
		S_DONE
	} state_t;

	state_t                   state_q;
	remap_job_t               job_s1;
	logic [2*DATA_W-1:0]      prod_a_s2;
	logic signed [33:0]       prod_b_s2;
	logic [DATA_W-1:0]        range_s2;
	logic                     flat_s2;
	logic [DIVIDEND_W-1:0]    quo_q;
	logic [DIVISOR_W-1:0]     rem_q;
	logic [DIVISOR_W-1:0]     div_d_q;
	logic [DIV_CNT_W-1:0]     cnt_q;
	logic [DATA_W-1:0]        res_q;
	logic                     out_valid_q;
	logic [DATA_W-1:0]        pixel_out_q;

	logic [DATA_W-1:0]        fmax;
	logic [DATA_W-1:0]        range;
	logic signed [16:0]       offset;
	logic signed [16:0]       delta;
	logic signed [NUM_W-1:0]  sum;
	logic signed [NUM_W-1:0]  num;
	logic [DIVISOR_W:0]       trial;
	logic                     fits;
	logic                     load_out;

	assign fmax   = format_max(pixel_format);
	assign pop    = (state_q == S_IDLE) && !q_status.empty;
	assign range  = job_s1.max_seen - job_s1.min_seen;
	assign offset = $signed({1'b0, job_s1.pixel}) - $signed({1'b0, job_s1.min_seen});
	assign delta  = $signed({1'b0, out_max}) - $signed({1'b0, out_min});
	assign sum    = $signed({4'b0, prod_a_s2}) + NUM_W'(prod_b_s2);
	assign num    = (sum <<< 1) + $signed({20'b0, range_s2});
	assign trial  = {rem_q, quo_q[DIVIDEND_W-1]};
	assign fits   = (trial >= {1'b0, div_d_q});

	// A finished result moves to the output register once that register is free.
	assign load_out = (state_q == S_DONE) && (!out_valid_q || !out_stall);

	assign out_valid = out_valid_q;
	assign pixel_out = pixel_out_q;

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				job_s1 <= head_job;
			end
			S_MUL: begin
				prod_a_s2 <= out_min * range;
				prod_b_s2 <= offset * delta;
				range_s2  <= range;
				flat_s2   <= (job_s1.max_seen <= job_s1.min_seen);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			pixel_out_q <= '0;
			quo_q       <= '0;
			rem_q       <= '0;
			div_d_q     <= '0;
			cnt_q       <= '0;
			res_q       <= '0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (!q_status.empty) begin
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					state_q <= S_SUM;
				end
				S_SUM: begin
					if (flat_s2) begin
						res_q   <= (out_min > fmax) ? fmax : out_min;
						state_q <= S_DONE;
					end else if (num < 0) begin
						res_q   <= '0;
						state_q <= S_DONE;
					end else begin
						quo_q   <= num[DIVIDEND_W-1:0];
						rem_q   <= '0;
						div_d_q <= {range_s2, 1'b0};
						cnt_q   <= DIV_CNT_W'(DIVIDEND_W);
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					rem_q <= fits ? DIVISOR_W'(trial - {1'b0, div_d_q})
					              : trial[DIVISOR_W-1:0];
					quo_q <= {quo_q[DIVIDEND_W-2:0], fits};
					cnt_q <= cnt_q - DIV_CNT_W'(1);
					if (cnt_q == DIV_CNT_W'(1)) begin
						state_q <= S_CLAMP;
					end
				end
				S_CLAMP: begin
					res_q   <= ((|quo_q[DIVIDEND_W-1:DATA_W]) || (quo_q[DATA_W-1:0] > fmax))
					           ? fmax : quo_q[DATA_W-1:0];
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (load_out) begin
						pixel_out_q <= res_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_divisor_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (div_d_q != '0))
		else $error("divide step with a zero divisor");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_DONE))
		else $error("result register loaded outside the done state");

endmodule

>>> design/min_max_contrast_stretch.sv
// Linear min/max contrast stretch for grey-level pixels, streamed in two passes.
// Input channel (in_valid / in_stall) carries one pixel per beat with an action bit:
// a measure beat updates the running minimum and maximum (frame_start clears them
// first), a remap beat produces one output beat on pixel_out (out_valid / out_stall)
// equal to out_min + (p - min) * (out_max - out_min) / (max - min), rounded half up
// and clamped to the pixel format maximum. A flat range yields out_min, clamped too.
// Measure beats are taken one per cycle unless the job queue is full, and give no
// result. Remap beats go into a four-entry job queue with a snapshot of the measured
// range; the back end works on one job at a time: two products, one sum, then a
// restoring divider that retires one quotient bit per cycle, then a clamp. The divider
// sets the sustained remap rate; a flat range or a negative numerator (which yields
// zero) skips the divider.
// in_stall rises only while the job queue is full, so measure beats keep flowing while
// the back end computes. When the receiver stalls, the finished result waits in the
// output register; the back end may finish the next job and holds it until that
// register frees. The user writes the configuration (pixel_format, out_min, out_max)
// with write_en / write_index / write_data only while idle; the block does not check it.
// Reset clears the queue and output valid, sets the range to empty (minimum at the
// wide format maximum, maximum at zero) and loads the register reset values.
module min_max_contrast_stretch
	import mmcs_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 write_en,
	input  logic [CFG_IDX_W-1:0] write_index,
	input  logic [DATA_W-1:0]    write_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 action,
	input  logic [DATA_W-1:0]    pixel_value,
	input  logic                 frame_start,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [DATA_W-1:0]    pixel_out
);

	logic              pixel_format_q;
	logic [DATA_W-1:0] out_min_q;
	logic [DATA_W-1:0] out_max_q;

	queue_status_t q_status;
	remap_job_t    push_job;
	remap_job_t    head_job;
	logic          push;
	logic          pop;

	// Configuration registers; an index past the last register is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_format_q <= FMT_NARROW;
			out_min_q      <= '0;
			out_max_q      <= DATA_W'(255);
		end else if (write_en) begin
			unique case (write_index)
				REG_PIXEL_FORMAT: pixel_format_q <= write_data[0];
				REG_OUT_MIN:      out_min_q      <= write_data;
				REG_OUT_MAX:      out_max_q      <= write_data;
				default: begin
				end
			endcase
		end
	end

	// The front end measures and sorts beats; remap beats become queued jobs.
	mmcs_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.action       (action),
		.pixel_value  (pixel_value),
		.frame_start  (frame_start),
		.pixel_format (pixel_format_q),
		.q_status     (q_status),
		.push         (push),
		.push_job     (push_job)
	);

	mmcs_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head_job (head_job),
		.status   (q_status)
	);

	// The back end does the rounded rational division and owns the output register.
	mmcs_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_status     (q_status),
		.head_job     (head_job),
		.pop          (pop),
		.pixel_format (pixel_format_q),
		.out_min      (out_min_q),
		.out_max      (out_max_q),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.pixel_out    (pixel_out)
	);

endmodule
